/* hw/rtl/min_curvature_band_tracker_defines.svh */
// assertion helpers for the band tracker rtl
`ifndef MIN_CURVATURE_BAND_TRACKER_DEFINES_SVH
`define MIN_CURVATURE_BAND_TRACKER_DEFINES_SVH

// condition must hold at every clock edge out of reset
`define MCT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define MCT_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/mct_pkg.sv */
package mct_pkg;

    localparam int MAX_POINTS = 256;
    localparam int MAX_BANDS  = 4;
    localparam int VALUE_BITS = 24;

    localparam int BAND_BITS   = $clog2(MAX_BANDS);
    localparam int POINT_BITS  = $clog2(MAX_POINTS);
    localparam int CNT_BITS    = $clog2(MAX_BANDS + 1);
    localparam int ADDR_BITS   = BAND_BITS + POINT_BITS;
    localparam int STORE_DEPTH = MAX_BANDS * MAX_POINTS;
    localparam int PRED_BITS   = VALUE_BITS + 2;
    localparam int DIFF_BITS   = VALUE_BITS + 3;
    localparam int ABS_BITS    = VALUE_BITS + 2;
    localparam int SQ_BITS     = 2 * ABS_BITS;
    localparam int COST_BITS   = SQ_BITS + CNT_BITS;

    localparam int NP_BITS     = 9;
    localparam int NB_BITS     = 3;
    localparam int AN_BITS     = 8;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 9;

    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_RUN  = 2'd1,
        KIND_READ = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_NUM_POINTS  = 2'd0,
        REG_NUM_BANDS   = 2'd1,
        REG_ANCHOR      = 2'd2
    } cfg_reg_t;

    localparam logic RESULT_READ = 1'b0;
    localparam logic RESULT_RUN  = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_BAD  = 1'b1;

    typedef struct packed {
        logic [1:0]                   kind;
        logic [1:0]                   band_index;
        logic [7:0]                   point_index;
        logic signed [VALUE_BITS-1:0] sample_value;
    } req_t;

    typedef struct packed {
        logic                         result_kind;
        logic signed [VALUE_BITS-1:0] tracked_value;
        logic                         run_status;
    } rsp_t;

    typedef logic [MAX_BANDS-1:0][BAND_BITS-1:0] perm_t;

    typedef struct packed {
        logic  valid;
        perm_t perm;
    } perm_step_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } term_ctl_t;

    function automatic perm_t perm_identity();
        perm_t p;
        for (int k = 0; k < MAX_BANDS; k++)
        begin
            p[k] = BAND_BITS'(k);
        end
        return p;
    endfunction

    // lexicographic successor over the first n entries
    function automatic perm_step_t perm_next(perm_t p, logic [CNT_BITS-1:0] n);
        perm_step_t       r;
        perm_t            q;
        int               ip;
        int               jp;
        int               nn;
        logic             found;
        logic [BAND_BITS-1:0] t;
        nn    = int'(n);
        ip    = 1;
        jp    = 0;
        found = 1'b0;
        for (int k = 1; k < MAX_BANDS; k++)
        begin
            if (k < nn && p[k-1] < p[k])
            begin
                ip    = k;
                found = 1'b1;
            end
        end
        for (int k = 0; k < MAX_BANDS; k++)
        begin
            if (found && k >= ip && k < nn && p[k] > p[ip-1])
            begin
                jp = k;
            end
        end
        q = p;
        if (found)
        begin
            t         = q[ip-1];
            q[ip-1]   = q[jp];
            q[jp]     = t;
        end
        r.perm = q;
        for (int k = 0; k < MAX_BANDS; k++)
        begin
            if (found && k >= ip && k < nn)
            begin
                r.perm[k] = q[nn - 1 + ip - k];
            end
        end
        r.valid = found;
        return r;
    endfunction

endpackage

/* hw/rtl/mct_ram.sv */
module mct_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/mct_cost_unit.sv */
module mct_cost_unit
    import mct_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  term_ctl_t                    term,
    input  logic signed [VALUE_BITS-1:0] cand,
    input  logic signed [PRED_BITS-1:0]  pred,
    output logic                         done,
    output logic [COST_BITS-1:0]         cost
);

    term_ctl_t              s1_reg;
    term_ctl_t              s2_reg;
    logic                   done_reg;
    logic [ABS_BITS-1:0]    absd_reg;
    logic [SQ_BITS-1:0]     prod_reg;
    logic [COST_BITS-1:0]   acc_reg;
    logic signed [DIFF_BITS-1:0] diff;
    logic [DIFF_BITS-1:0]   mag;

    assign diff = DIFF_BITS'(cand) - DIFF_BITS'(pred);
    assign mag  = diff[DIFF_BITS-1] ? (~diff + 1'b1) : diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg   <= '0;
            s2_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            s1_reg   <= term;
            s2_reg   <= s1_reg;
            done_reg <= s2_reg.valid && s2_reg.last;
        end
    end

    // subtract, square, accumulate: one term enters per cycle
    always_ff @(posedge clk)
    begin
        if (term.valid)
        begin
            absd_reg <= mag[ABS_BITS-1:0];
        end
        if (s1_reg.valid)
        begin
            prod_reg <= absd_reg * absd_reg;
        end
        if (s2_reg.valid)
        begin
            acc_reg <= s2_reg.first ? COST_BITS'(prod_reg)
                                    : acc_reg + COST_BITS'(prod_reg);
        end
    end

    assign done = done_reg;
    assign cost = acc_reg;

endmodule

/* hw/rtl/min_curvature_band_tracker.sv */
// Band tracker. Load requests write one Q16.8 sample into the sample store. Read requests
// return a tracked value from the tracked store through the registered response. A run
// request with a bad configuration reports status 1 in the same way; a good run copies the
// anchor column, then for each point fetches nb samples, scores all nb! band orders on one
// shared subtract/square/accumulate pipeline and writes the winner back. The block takes
// no new request until the current one is finished, and a read or run whose response
// finds the previous response still held off waits, stalling new requests, until that
// response is taken.
module min_curvature_band_tracker
    import mct_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_stall,
    input  req_t                     req,
    output logic                     rsp_valid,
    input  logic                     rsp_stall,
    output rsp_t                     rsp,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

`include "min_curvature_band_tracker_defines.svh"

    typedef enum logic [3:0] {
        S_IDLE,
        S_ANC_RD,
        S_ANC_CAP,
        S_FETCH_RD,
        S_FETCH_CAP,
        S_TERM,
        S_WAIT,
        S_COMMIT,
        S_RESULT
    } state_t;

    state_t                state_reg;
    logic [NP_BITS-1:0]    num_points_reg;
    logic [NB_BITS-1:0]    num_bands_reg;
    logic [AN_BITS-1:0]    anchor_reg;
    logic                  rsp_valid_reg;
    rsp_t                  rsp_reg;
    logic                  res_read_reg;
    logic                  res_status_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [POINT_BITS-1:0] pt_reg;
    logic                  dir_up_reg;
    perm_t                 perm_reg;
    perm_t                 best_perm_reg;
    logic [COST_BITS-1:0]  best_cost_reg;

    logic signed [VALUE_BITS-1:0] anchor_vals_reg [MAX_BANDS];
    logic signed [VALUE_BITS-1:0] cur_reg         [MAX_BANDS];
    logic signed [VALUE_BITS-1:0] prev_reg        [MAX_BANDS];
    logic signed [VALUE_BITS-1:0] now_reg         [MAX_BANDS];
    logic signed [PRED_BITS-1:0]  pred_reg        [MAX_BANDS];

    logic                  accept;
    logic                  out_free;
    logic                  cfg_bad;
    logic                  cnt_last;
    logic [BAND_BITS-1:0]  band;
    perm_step_t            step;
    term_ctl_t             term;
    logic                  cu_done;
    logic [COST_BITS-1:0]  cu_cost;
    logic                  cost_better;
    logic                  up_more;

    logic                  s_we;
    logic [ADDR_BITS-1:0]  s_waddr;
    logic                  s_re;
    logic [ADDR_BITS-1:0]  s_raddr;
    logic [VALUE_BITS-1:0] s_rdata;
    logic                  t_we;
    logic [ADDR_BITS-1:0]  t_waddr;
    logic [VALUE_BITS-1:0] t_wdata;
    logic                  t_re;
    logic [VALUE_BITS-1:0] t_rdata;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign cfg_bad = (num_bands_reg < NB_BITS'(2))
                  || (num_bands_reg > NB_BITS'(MAX_BANDS))
                  || (num_points_reg > NP_BITS'(MAX_POINTS))
                  || (anchor_reg == '0)
                  || ({2'b0, anchor_reg} + 10'd1 >= {1'b0, num_points_reg});

    assign band        = cnt_reg[BAND_BITS-1:0];
    assign cnt_last    = (cnt_reg + 1'b1 == num_bands_reg);
    assign step        = perm_next(perm_reg, num_bands_reg);
    assign cost_better = (cu_cost < best_cost_reg);
    assign up_more     = ({1'b0, pt_reg} + 9'd1 < num_points_reg);

    assign term.valid = (state_reg == S_TERM);
    assign term.first = (cnt_reg == '0);
    assign term.last  = cnt_last;

    // sample store: loads write, the walk reads
    assign s_we    = accept && (req.kind == KIND_LOAD);
    assign s_waddr = {req.band_index, req.point_index};
    assign s_re    = (state_reg == S_ANC_RD) || (state_reg == S_FETCH_RD);
    assign s_raddr = (state_reg == S_ANC_RD) ? {band, anchor_reg} : {band, pt_reg};

    // tracked store: anchor copy and commits write, read requests read
    always_comb
    begin
        t_we    = 1'b0;
        t_waddr = {band, pt_reg};
        t_wdata = now_reg[best_perm_reg[band]];
        case (state_reg)
            S_ANC_CAP:
            begin
                t_we    = 1'b1;
                t_waddr = {band, anchor_reg};
                t_wdata = s_rdata;
            end
            S_COMMIT:
            begin
                t_we = 1'b1;
            end
            default:
            begin
                t_we = 1'b0;
            end
        endcase
    end

    assign t_re = accept && (req.kind == KIND_READ);

    mct_ram #(.WIDTH(VALUE_BITS), .DEPTH(STORE_DEPTH)) u_sample_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (req.sample_value),
        .re    (s_re),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    mct_ram #(.WIDTH(VALUE_BITS), .DEPTH(STORE_DEPTH)) u_tracked_ram (
        .clk   (clk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .re    (t_re),
        .raddr ({req.band_index, req.point_index}),
        .rdata (t_rdata)
    );

    mct_cost_unit u_cost (
        .clk   (clk),
        .rst_n (rst_n),
        .term  (term),
        .cand  (now_reg[perm_reg[band]]),
        .pred  (pred_reg[band]),
        .done  (cu_done),
        .cost  (cu_cost)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            num_points_reg <= NP_BITS'(MAX_POINTS);
            num_bands_reg  <= NB_BITS'(MAX_BANDS);
            anchor_reg     <= AN_BITS'(1);
            rsp_valid_reg  <= 1'b0;
            rsp_reg        <= '0;
            res_read_reg   <= 1'b0;
            res_status_reg <= STATUS_OK;
            cnt_reg        <= '0;
            pt_reg         <= '0;
            dir_up_reg     <= 1'b1;
            perm_reg       <= perm_identity();
            best_perm_reg  <= perm_identity();
            best_cost_reg  <= '1;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_NUM_POINTS: num_points_reg <= cfg_data;
                    REG_NUM_BANDS:  num_bands_reg  <= cfg_data[NB_BITS-1:0];
                    REG_ANCHOR:     anchor_reg     <= cfg_data[AN_BITS-1:0];
                    default:        ;
                endcase
            end
            if (rsp_valid_reg && !rsp_stall && state_reg != S_RESULT)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (req.kind)
                            KIND_RUN:
                            begin
                                cnt_reg <= '0;
                                if (cfg_bad)
                                begin
                                    res_read_reg   <= 1'b0;
                                    res_status_reg <= STATUS_BAD;
                                    state_reg      <= S_RESULT;
                                end
                                else
                                begin
                                    state_reg <= S_ANC_RD;
                                end
                            end
                            KIND_READ:
                            begin
                                res_read_reg <= 1'b1;
                                state_reg    <= S_RESULT;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_ANC_RD:
                begin
                    state_reg <= S_ANC_CAP;
                end
                S_ANC_CAP:
                begin
                    if (cnt_last)
                    begin
                        cnt_reg    <= '0;
                        dir_up_reg <= 1'b1;
                        pt_reg     <= anchor_reg + 1'b1;
                        state_reg  <= S_FETCH_RD;
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg + 1'b1;
                        state_reg <= S_ANC_RD;
                    end
                end
                S_FETCH_RD:
                begin
                    state_reg <= S_FETCH_CAP;
                end
                S_FETCH_CAP:
                begin
                    cnt_reg <= cnt_last ? '0 : cnt_reg + 1'b1;
                    if (cnt_last)
                    begin
                        perm_reg      <= perm_identity();
                        best_perm_reg <= perm_identity();
                        best_cost_reg <= '1;
                        state_reg     <= S_TERM;
                    end
                    else
                    begin
                        state_reg <= S_FETCH_RD;
                    end
                end
                S_TERM:
                begin
                    if (cnt_last)
                    begin
                        state_reg <= S_WAIT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_WAIT:
                begin
                    if (cu_done)
                    begin
                        cnt_reg <= '0;
                        if (cost_better)
                        begin
                            best_cost_reg <= cu_cost;
                            best_perm_reg <= perm_reg;
                        end
                        if (step.valid)
                        begin
                            perm_reg  <= step.perm;
                            state_reg <= S_TERM;
                        end
                        else
                        begin
                            state_reg <= S_COMMIT;
                        end
                    end
                end
                S_COMMIT:
                begin
                    if (cnt_last)
                    begin
                        cnt_reg <= '0;
                        if (dir_up_reg && up_more)
                        begin
                            pt_reg    <= pt_reg + 1'b1;
                            state_reg <= S_FETCH_RD;
                        end
                        else if (dir_up_reg)
                        begin
                            dir_up_reg <= 1'b0;
                            pt_reg     <= anchor_reg - 1'b1;
                            state_reg  <= S_FETCH_RD;
                        end
                        else if (pt_reg != '0)
                        begin
                            pt_reg    <= pt_reg - 1'b1;
                            state_reg <= S_FETCH_RD;
                        end
                        else
                        begin
                            res_read_reg   <= 1'b0;
                            res_status_reg <= STATUS_OK;
                            state_reg      <= S_RESULT;
                        end
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_RESULT:
                begin
                    if (out_free)
                    begin
                        rsp_valid_reg <= 1'b1;
                        if (res_read_reg)
                        begin
                            rsp_reg.result_kind   <= RESULT_READ;
                            rsp_reg.tracked_value <= t_rdata;
                            rsp_reg.run_status    <= STATUS_OK;
                        end
                        else
                        begin
                            rsp_reg.result_kind   <= RESULT_RUN;
                            rsp_reg.tracked_value <= '0;
                            rsp_reg.run_status    <= res_status_reg;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // band value registers of the walk
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_ANC_CAP:
            begin
                anchor_vals_reg[band] <= s_rdata;
                cur_reg[band]         <= s_rdata;
                prev_reg[band]        <= s_rdata;
            end
            S_FETCH_CAP:
            begin
                now_reg[band] <= s_rdata;
                if (cnt_last)
                begin
                    for (int b = 0; b < MAX_BANDS; b++)
                    begin
                        pred_reg[b] <= {cur_reg[b][VALUE_BITS-1], cur_reg[b], 1'b0}
                                     - {{2{prev_reg[b][VALUE_BITS-1]}}, prev_reg[b]};
                    end
                end
            end
            S_COMMIT:
            begin
                if (cnt_last)
                begin
                    for (int b = 0; b < MAX_BANDS; b++)
                    begin
                        if (dir_up_reg && !up_more)
                        begin
                            // downward walk restarts from the anchor with zero slope
                            cur_reg[b]  <= anchor_vals_reg[b];
                            prev_reg[b] <= anchor_vals_reg[b];
                        end
                        else
                        begin
                            prev_reg[b] <= cur_reg[b];
                            cur_reg[b]  <= now_reg[best_perm_reg[b]];
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    `MCT_ASSERT_IMPLY(a_done_in_wait, cu_done, state_reg == S_WAIT,
        "cost unit finished outside the wait state")
    `MCT_ASSERT_IMPLY(a_term_in_range, term.valid, cnt_reg < num_bands_reg,
        "cost term issued beyond the band count")
    `MCT_ASSERT_ALWAYS(a_commit_has_best, state_reg != S_COMMIT || best_cost_reg != '1,
        "commit without a scored band order")

endmodule

/* dv/min_curvature_band_tracker_checker.sv */
module min_curvature_band_tracker_checker
    import mct_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    input  logic                     req_stall,
    input  req_t                     req,
    input  logic                     rsp_valid,
    input  logic                     rsp_stall,
    input  rsp_t                     rsp,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output int                       errors,
    output int                       pending
);

    logic signed [VALUE_BITS-1:0] samples [STORE_DEPTH];
    logic signed [VALUE_BITS-1:0] tracks  [STORE_DEPTH];
    logic [NP_BITS-1:0]           points_q;
    logic [NB_BITS-1:0]           bands_q;
    logic [AN_BITS-1:0]           anchor_q;
    longint                       cur_val  [MAX_BANDS];
    longint                       prev_val [MAX_BANDS];
    rsp_t                         awaited_results [$];

    // choose the band order at one point that best fits the straight-line guess
    function automatic void track_column(int nb, int pt);
        longint pred [MAX_BANDS];
        longint now  [MAX_BANDS];
        int     digit [MAX_BANDS];
        int     best_order [MAX_BANDS];
        longint cost;
        longint best_cost;
        logic   found;
        logic   distinct;
        int     total;
        int     c;
        total = 1;
        for (int b = 0; b < nb; b++)
        begin
            total = total * nb;
            pred[b] = 2 * cur_val[b] - prev_val[b];
            now[b] = longint'(samples[b * MAX_POINTS + pt]);
            best_order[b] = b;
        end
        found = 1'b0;
        best_cost = 0;
        // counting in base nb, keeping tuples with distinct digits, is lexicographic order
        for (int code = 0; code < total; code++)
        begin
            c = code;
            for (int b = nb - 1; b >= 0; b--)
            begin
                digit[b] = c % nb;
                c = c / nb;
            end
            distinct = 1'b1;
            for (int i = 0; i < nb; i++)
            begin
                for (int j = i + 1; j < nb; j++)
                begin
                    if (digit[i] == digit[j])
                    begin
                        distinct = 1'b0;
                    end
                end
            end
            if (distinct)
            begin
                cost = 0;
                for (int b = 0; b < nb; b++)
                begin
                    cost = cost + (now[digit[b]] - pred[b]) * (now[digit[b]] - pred[b]);
                end
                if (!found || cost < best_cost)
                begin
                    found = 1'b1;
                    best_cost = cost;
                    for (int b = 0; b < nb; b++)
                    begin
                        best_order[b] = digit[b];
                    end
                end
            end
        end
        for (int b = 0; b < nb; b++)
        begin
            prev_val[b] = cur_val[b];
            cur_val[b] = now[best_order[b]];
            tracks[b * MAX_POINTS + pt] = cur_val[b][VALUE_BITS-1:0];
        end
    endfunction

    function automatic logic track_bands();
        int nb;
        int np;
        int an;
        nb = int'(bands_q);
        np = int'(points_q);
        an = int'(anchor_q);
        if (nb < 2 || nb > MAX_BANDS || np > MAX_POINTS || an == 0 || an + 1 >= np)
        begin
            return STATUS_BAD;
        end
        for (int b = 0; b < nb; b++)
        begin
            tracks[b * MAX_POINTS + an] = samples[b * MAX_POINTS + an];
        end
        for (int dir = 1; dir >= -1; dir -= 2)
        begin
            for (int b = 0; b < nb; b++)
            begin
                cur_val[b] = longint'(samples[b * MAX_POINTS + an]);
                prev_val[b] = cur_val[b];
            end
            for (int pt = an + dir; pt >= 0 && pt < np; pt += dir)
            begin
                track_column(nb, pt);
            end
        end
        return STATUS_OK;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t e;
        int   addr;
        if (!rst_n)
        begin
            points_q = NP_BITS'(256);
            bands_q = NB_BITS'(4);
            anchor_q = AN_BITS'(1);
            for (int b = 0; b < MAX_BANDS; b++)
            begin
                cur_val[b] = 0;
                prev_val[b] = 0;
            end
            awaited_results.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_NUM_POINTS: points_q = cfg_data[NP_BITS-1:0];
                    REG_NUM_BANDS:  bands_q = cfg_data[NB_BITS-1:0];
                    REG_ANCHOR:     anchor_q = cfg_data[AN_BITS-1:0];
                    default: ;
                endcase
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, actual %p", $time, rsp);
                end
                else
                begin
                    e = awaited_results.pop_front();
                    if (rsp.result_kind !== e.result_kind)
                    begin
                        errors++;
                        $display("%0t: result_kind expected %0d actual %0d",
                                 $time, e.result_kind, rsp.result_kind);
                    end
                    if (rsp.tracked_value !== e.tracked_value)
                    begin
                        errors++;
                        $display("%0t: tracked_value expected %0d actual %0d",
                                 $time, e.tracked_value, rsp.tracked_value);
                    end
                    if (rsp.run_status !== e.run_status)
                    begin
                        errors++;
                        $display("%0t: run_status expected %0d actual %0d",
                                 $time, e.run_status, rsp.run_status);
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                addr = int'(req.band_index) * MAX_POINTS + int'(req.point_index);
                case (req.kind)
                    KIND_LOAD: samples[addr] = req.sample_value;
                    KIND_RUN:
                    begin
                        e.result_kind = RESULT_RUN;
                        e.tracked_value = '0;
                        e.run_status = track_bands();
                        awaited_results.push_back(e);
                    end
                    KIND_READ:
                    begin
                        e.result_kind = RESULT_READ;
                        e.tracked_value = tracks[addr];
                        e.run_status = STATUS_OK;
                        awaited_results.push_back(e);
                    end
                    default: ;
                endcase
            end
            pending = awaited_results.size();
        end
    end

endmodule

/* dv/min_curvature_band_tracker_test.sv */
module min_curvature_band_tracker_test;
    import mct_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic                     clk;
    logic                     rst_n;
    logic                     req_valid;
    logic                     req_stall;
    req_t                     req;
    logic                     rsp_valid;
    logic                     rsp_stall;
    rsp_t                     rsp;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    int                       errors;
    int                       pending;

    bit  sample_ok  [STORE_DEPTH];
    bit  tracked_ok [STORE_DEPTH];
    int  cfg_np;
    int  cfg_nb;
    int  cfg_an;
    bit  cfg_good;
    bit  calm;
    bit  hold_go;
    bit  wild;
    int  curve_base  [MAX_BANDS];
    int  curve_slope [MAX_BANDS];
    int  curve_bend  [MAX_BANDS];
    int  sent;
    int  n_loads;
    int  n_runs;
    int  n_bad_runs;
    int  n_reads;
    int  n_settings;

    min_curvature_band_tracker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    min_curvature_band_tracker_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        #2 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // result side: random stalls, one long hold-off on request
    initial
    begin
        bit held;
        held = 1'b0;
        rsp_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_go && !held)
            begin
                held = 1'b1;
                rsp_stall <= 1'b1;
                for (int n = 0; n < 400; n++)
                begin
                    @(posedge clk);
                end
            end
            rsp_stall <= !calm && $urandom_range(99) < 35;
        end
    end

    task automatic send(logic [1:0] k, int band, int point, logic [VALUE_BITS-1:0] v);
        req_t r;
        r.kind = k;
        r.band_index = band[1:0];
        r.point_index = point[7:0];
        r.sample_value = v;
        while (!calm && $urandom_range(99) < 35)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        case (k)
            KIND_LOAD:
            begin
                n_loads++;
                sample_ok[band * MAX_POINTS + point] = 1'b1;
            end
            KIND_RUN:
            begin
                n_runs++;
                if (!cfg_good)
                begin
                    n_bad_runs++;
                end
            end
            KIND_READ: n_reads++;
            default: ;
        endcase
        if (k != KIND_UNUSED)
        begin
            sent++;
        end
    endtask

    task automatic settle();
        req_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_cfg(int np, int nb, int an);
        settle();
        cfg_we <= 1'b1;
        cfg_index <= REG_NUM_POINTS;
        cfg_data <= CFG_DATA_BITS'(np);
        @(posedge clk);
        cfg_index <= REG_NUM_BANDS;
        cfg_data <= CFG_DATA_BITS'(nb);
        @(posedge clk);
        cfg_index <= REG_ANCHOR;
        cfg_data <= CFG_DATA_BITS'(an);
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_np = np;
        cfg_nb = nb;
        cfg_an = an;
        cfg_good = nb >= 2 && nb <= MAX_BANDS && np <= MAX_POINTS && an != 0 && an + 1 < np;
        n_settings++;
    endtask

    task automatic run_tracking_once();
        bit ready;
        ready = 1'b1;
        if (cfg_good)
        begin
            for (int b = 0; b < cfg_nb; b++)
            begin
                for (int p = 0; p < cfg_np; p++)
                begin
                    ready &= sample_ok[b * MAX_POINTS + p];
                end
            end
        end
        if (ready)
        begin
            send(KIND_RUN, $urandom_range(3), $urandom_range(255), VALUE_BITS'($urandom));
            if (cfg_good)
            begin
                for (int b = 0; b < cfg_nb; b++)
                begin
                    for (int p = 0; p < cfg_np; p++)
                    begin
                        tracked_ok[b * MAX_POINTS + p] = 1'b1;
                    end
                end
            end
        end
    endtask

    task automatic read_some();
        int b;
        int p;
        int span;
        span = (cfg_np > 0 && cfg_np <= MAX_POINTS) ? cfg_np : MAX_POINTS;
        for (int t = 0; t < 30; t++)
        begin
            b = $urandom_range(3);
            p = $urandom_range(1) ? $urandom_range(span - 1) : $urandom_range(255);
            if (tracked_ok[b * MAX_POINTS + p])
            begin
                send(KIND_READ, b, p, VALUE_BITS'($urandom));
                return;
            end
        end
    endtask

    function automatic logic [VALUE_BITS-1:0] curve_at(int k, int p);
        if (wild)
        begin
            return VALUE_BITS'($urandom);
        end
        return VALUE_BITS'(curve_base[k] + curve_slope[k] * p + curve_bend[k] * p * p / 16
                           + $signed($urandom_range(128)) - 64);
    endfunction

    // fresh curves, dealt to the bands in a shuffled order at every point
    task automatic load_region(int np, int nb);
        int order [MAX_BANDS];
        int j;
        int t;
        wild = $urandom_range(4) == 0;
        for (int k = 0; k < MAX_BANDS; k++)
        begin
            curve_base[k] = $signed($urandom_range(1 << 21)) - (1 << 20);
            curve_slope[k] = $signed($urandom_range(1 << 13)) - (1 << 12);
            curve_bend[k] = $signed($urandom_range(128)) - 64;
        end
        for (int p = 0; p < np; p++)
        begin
            for (int k = 0; k < MAX_BANDS; k++)
            begin
                order[k] = k;
            end
            for (int k = MAX_BANDS - 1; k > 0; k--)
            begin
                j = $urandom_range(k);
                t = order[k];
                order[k] = order[j];
                order[j] = t;
            end
            for (int b = 0; b < nb; b++)
            begin
                send(KIND_LOAD, b, p, curve_at(order[b], p));
            end
        end
    endtask

    task automatic mixed_ops(int count);
        int r;
        int span;
        span = (cfg_np > 0 && cfg_np <= MAX_POINTS) ? cfg_np : MAX_POINTS;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 45)
            begin
                send(KIND_LOAD, $urandom_range(3),
                     $urandom_range(1) ? $urandom_range(span - 1) : $urandom_range(255),
                     $urandom_range(1) ? curve_at($urandom_range(3), i)
                                       : VALUE_BITS'($urandom));
            end
            else if (r < 85)
            begin
                read_some();
            end
            else if (r < 93)
            begin
                run_tracking_once();
            end
            else
            begin
                send(KIND_UNUSED, $urandom_range(3), $urandom_range(255),
                     VALUE_BITS'($urandom));
            end
        end
    endtask

    initial
    begin
        int np;
        int nb;
        int an;
        bit pressure_done;
        clk = 1'b0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_index = REG_NUM_POINTS;
        cfg_data = '0;
        calm = 1'b0;
        hold_go = 1'b0;
        pressure_done = 1'b0;
        cfg_np = 256;
        cfg_nb = 4;
        cfg_an = 1;
        cfg_good = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: smallest setting, value extremes, unused kind, bad settings
        set_cfg(3, 2, 1);
        send(KIND_LOAD, 0, 0, 24'h800000);
        send(KIND_LOAD, 1, 0, 24'h7FFFFF);
        send(KIND_LOAD, 0, 1, 24'h7FFFFF);
        send(KIND_LOAD, 1, 1, 24'h800000);
        send(KIND_LOAD, 0, 2, 24'h000000);
        send(KIND_LOAD, 1, 2, 24'hFFFFFF);
        send(KIND_UNUSED, 0, 0, 24'h123456);
        run_tracking_once();
        for (int p = 0; p < 3; p++)
        begin
            send(KIND_READ, 0, p, 24'h0);
            send(KIND_READ, 1, p, 24'h0);
        end
        set_cfg(3, 2, 0);
        run_tracking_once();
        set_cfg(3, 2, 2);
        run_tracking_once();
        set_cfg(3, 1, 1);
        run_tracking_once();
        set_cfg(3, 5, 1);
        run_tracking_once();
        set_cfg(511, 7, 255);
        run_tracking_once();
        set_cfg(256, 4, 255);
        run_tracking_once();

        // full-size settings
        set_cfg(256, 4, 1);
        load_region(256, 4);
        run_tracking_once();
        repeat (40) read_some();
        set_cfg(256, 4, 254);
        run_tracking_once();
        repeat (20) read_some();
        set_cfg(256, 2, 128);
        // back-to-back stretch with no idling on either side
        calm = 1'b1;
        load_region(256, 2);
        calm = 1'b0;
        run_tracking_once();
        repeat (20) read_some();

        // random settings, mostly small and well formed
        while (sent < 1650)
        begin
            if (!pressure_done && sent >= 1000)
            begin
                pressure_done = 1'b1;
                hold_go = 1'b1;
            end
            if ($urandom_range(7) == 0)
            begin
                case ($urandom_range(3))
                    0: set_cfg($urandom_range(3, 256), $urandom_range(1), 1);
                    1: set_cfg($urandom_range(3, 256), $urandom_range(5, 7), 1);
                    2: set_cfg($urandom_range(257, 511), $urandom_range(2, 4), 1);
                    default:
                    begin
                        np = $urandom_range(0, 12);
                        set_cfg(np, $urandom_range(2, 4),
                                $urandom_range(1) ? 0 : $urandom_range(np < 1 ? 0 : np - 1, 255));
                    end
                endcase
                mixed_ops($urandom_range(8, 20));
            end
            else
            begin
                np = $urandom_range(3, 14);
                nb = $urandom_range(2, 4);
                an = $urandom_range(1, np - 2);
                set_cfg(np, nb, an);
                load_region(np, nb);
                run_tracking_once();
                mixed_ops($urandom_range(30, 60));
            end
        end
        calm = 1'b0;

        settle();
        $display("covered %0d loads, %0d reads and %0d runs (%0d under bad settings)",
                 n_loads, n_reads, n_runs, n_bad_runs);
        $display("across %0d register settings, with random stalls and one long hold-off",
                 n_settings);
        if (errors == 0 && pending == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/mct_pkg.sv
hw/rtl/mct_ram.sv
hw/rtl/mct_cost_unit.sv
hw/rtl/min_curvature_band_tracker.sv
dv/min_curvature_band_tracker_checker.sv
dv/min_curvature_band_tracker_test.sv
